// ===== design/ptcf_pkg.sv =====
// Package for the point transform and crop filter: fixed-point helpers,
// fixed mount tables, crop box bounds and register indexes. No dependencies.
package ptcf_pkg;

    localparam int unsigned NumRegs = 8;

    typedef logic signed [31:0] q_t;

    typedef enum logic [2:0] {
        REG_POSE_X = 3'd0,
        REG_POSE_Y = 3'd1,
        REG_POSE_Z = 3'd2,
        REG_QUAT_X = 3'd3,
        REG_QUAT_Y = 3'd4,
        REG_QUAT_Z = 3'd5,
        REG_QUAT_W = 3'd6,
        REG_POSE_VALID = 3'd7
    } reg_idx_t;

    localparam logic signed [33:0] QOne = 34'sd1073741824;

    // Sensor-to-body rotation (row-major, Q1.30) and offset (Q16.16).
    localparam q_t RadarRot [9] = '{
        32'sd564910498, -32'sd869876695, 32'sd277690906,
        -32'sd900513239, -32'sd584805636, 32'sd1825,
        32'sd151240831, -32'sd232891380, -32'sd1037212268
    };
    localparam q_t RadarOff [3] = '{32'sd18492, 32'sd0, 32'sd0};

    // Fixed mount transform that the pose is composed with.
    localparam q_t MountRot [9] = '{
        32'sd1046221821, 32'sd0, -32'sd241539512,
        32'sd0, 32'sd1073741824, 32'sd0,
        32'sd241539512, 32'sd0, 32'sd1046221821
    };
    localparam q_t MountOff [3] = '{-32'sd8501, 32'sd0, -32'sd10210};

    // Crop box bounds in Q16.16; the box is open on every face.
    localparam q_t BoxMin [3] = '{-32'sd45875, -32'sd26214, -32'sd39322};
    localparam q_t BoxMax [3] = '{32'sd26214, 32'sd26214, 32'sd6554};

    // Q1.30 product, rounded to nearest with halves toward plus infinity.
    function automatic logic signed [33:0] mulq30(input q_t a, input q_t b);
        logic signed [63:0] s;
        s = 64'(a) * 64'(b) + 64'sd536870912;
        return s[63:30] ;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic q_t sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== design/ptcf_pose.sv =====
// Pose register file and world transform builder for the point transform core.
// Depends on ptcf_pkg. Rebuilds the world transform after reset and each write.
module ptcf_pose
    import ptcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output q_t          rot_o [9],
    output q_t          off_o [3],
    output logic        pose_valid_o,
    output logic        busy_o
);

    q_t   regs_reg [7];
    logic valid_reg;
    logic [2:0] step_reg;
    q_t   rq_reg [9];
    logic signed [33:0] pq_reg [9];
    logic signed [33:0] mp_reg [12][3];
    q_t   rot_reg [9];
    q_t   off_reg [3];

    // Register writes restart the rebuild sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 7; i++) begin
                regs_reg[i] <= (i == int'(REG_QUAT_W)) ? 32'sd1073741824 : '0;
            end
            valid_reg <= 1'b0;
            step_reg  <= 3'd1;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_POSE_VALID) begin
                valid_reg <= cfg_wdata[0];
            end else begin
                regs_reg[cfg_index] <= cfg_wdata;
            end
            step_reg <= 3'd1;
        end else if (step_reg != 3'd0) begin
            step_reg <= (step_reg == 3'd4) ? 3'd0 : step_reg + 3'd1;
        end
    end

    // Stage 1: quaternion products.
    always_ff @(posedge aclk) begin
        pq_reg[0] <= mulq30(regs_reg[3], regs_reg[3]);
        pq_reg[1] <= mulq30(regs_reg[4], regs_reg[4]);
        pq_reg[2] <= mulq30(regs_reg[5], regs_reg[5]);
        pq_reg[3] <= mulq30(regs_reg[3], regs_reg[4]);
        pq_reg[4] <= mulq30(regs_reg[3], regs_reg[5]);
        pq_reg[5] <= mulq30(regs_reg[4], regs_reg[5]);
        pq_reg[6] <= mulq30(regs_reg[6], regs_reg[3]);
        pq_reg[7] <= mulq30(regs_reg[6], regs_reg[4]);
        pq_reg[8] <= mulq30(regs_reg[6], regs_reg[5]);
    end

    // Stage 2: rotation matrix from the quaternion, no normalization.
    always_ff @(posedge aclk) begin
        rq_reg[0] <= sat32(36'(QOne) - 36'(pq_reg[1] + pq_reg[2]) * 2);
        rq_reg[1] <= sat32(36'(pq_reg[3] - pq_reg[8]) * 2);
        rq_reg[2] <= sat32(36'(pq_reg[4] + pq_reg[7]) * 2);
        rq_reg[3] <= sat32(36'(pq_reg[3] + pq_reg[8]) * 2);
        rq_reg[4] <= sat32(36'(QOne) - 36'(pq_reg[0] + pq_reg[2]) * 2);
        rq_reg[5] <= sat32(36'(pq_reg[5] - pq_reg[6]) * 2);
        rq_reg[6] <= sat32(36'(pq_reg[4] - pq_reg[7]) * 2);
        rq_reg[7] <= sat32(36'(pq_reg[5] + pq_reg[6]) * 2);
        rq_reg[8] <= sat32(36'(QOne) - 36'(pq_reg[0] + pq_reg[1]) * 2);
    end

    // Stage 3: products of the rotation with the mount rotation and offset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    mp_reg[i*3+j][k] <= mulq30(rq_reg[i*3+k], MountRot[k*3+j]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                mp_reg[9+i][k] <= mulq30(rq_reg[i*3+k], MountOff[k]);
            end
        end
    end

    // Stage 4: sums, loaded on the last rebuild step.
    always_ff @(posedge aclk) begin
        if (step_reg == 3'd4) begin
            for (int i = 0; i < 9; i++) begin
                rot_reg[i] <= sat32(36'(mp_reg[i][0]) + 36'(mp_reg[i][1])
                                    + 36'(mp_reg[i][2]));
            end
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= sat32(36'(mp_reg[9+i][0]) + 36'(mp_reg[9+i][1])
                                    + 36'(mp_reg[9+i][2]) + 36'(regs_reg[i]));
            end
        end
    end

    assign rot_o = rot_reg;
    assign off_o = off_reg;
    assign pose_valid_o = valid_reg;

    // The transform outputs are not yet current while a rebuild runs.
    assign busy_o = (step_reg != 3'd0);

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 3'd4) else $error("rebuild step out of range");
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> step_reg == 3'd1) else $error("write did not restart rebuild");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == 3'd0 && !cfg_wr_en) |=> $stable(off_reg[0]))
        else $error("world offset changed while idle");

endmodule

// ===== design/point_transform_crop_filter_core.sv =====
// Top level of the point transform and crop filter.
// Depends on ptcf_pkg and ptcf_pose.
//
//  Channel   Direction  Content (lowest bits first)
//  s_axis    in         point_x, point_y, point_z, point_intensity
//  m_axis    out        map_x, map_y, map_z, map_intensity
//  cfg       in         write enable, register index, 32-bit data
//
// One item per cycle while no stall or pose rebuild holds the input, through a
// five-stage pipeline: multiply, sum and crop, multiply, sum, output register.
// Each multiply stage uses nine 32x32 multipliers.
// A stall holds every stage; empty slots are not squeezed out.
// Reset is synchronous, active low. The input is held off in a write cycle and
// after reset or a pose write while the world transform is rebuilt.
module point_transform_crop_filter_core
    import ptcf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // point_x, point_y, point_z, point_intensity
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // map_x, map_y, map_z, map_intensity
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    q_t   wrot [9];
    q_t   woff [3];
    logic pose_valid;
    logic pose_busy;

    ptcf_pose u_pose (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .rot_o(wrot), .off_o(woff), .pose_valid_o(pose_valid), .busy_o(pose_busy)
    );

    logic [3:0] v_reg;
    logic       adv;
    logic       out_v_reg;
    logic [127:0] out_reg;
    logic signed [33:0] p1_reg [9];
    logic [31:0] i1_reg, i2_reg, i3_reg, i4_reg;
    q_t   b2_reg [3];
    logic signed [33:0] p3_reg [9];
    q_t   m4_reg [3];
    logic keep2;

    // The pipeline moves whenever the output slot is free or being emptied.
    // New items wait while the world transform is being written or rebuilt.
    assign adv = !out_v_reg || m_axis_tready;
    assign s_axis_tready = adv && !pose_busy && !cfg_wr_en;

    always_comb begin
        keep2 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (b2_reg[i] <= BoxMin[i] || b2_reg[i] >= BoxMax[i]) keep2 = 1'b1;
        end
    end

    // Valid bits: stage 1 multiply, 2 sum, 3 multiply, 4 sum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= s_axis_tvalid && s_axis_tready && pose_valid;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1] && keep2;
            v_reg[3] <= v_reg[2];
            out_v_reg <= v_reg[3];
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    p1_reg[i*3+k] <= mulq30(RadarRot[i*3+k], s_axis_tdata[k*32 +: 32]);
                    p3_reg[i*3+k] <= mulq30(wrot[i*3+k], b2_reg[k]);
                end
                b2_reg[i] <= sat32(36'(p1_reg[i*3]) + 36'(p1_reg[i*3+1])
                                   + 36'(p1_reg[i*3+2]) + 36'(RadarOff[i]));
                m4_reg[i] <= sat32(36'(p3_reg[i*3]) + 36'(p3_reg[i*3+1])
                                   + 36'(p3_reg[i*3+2]) + 36'(woff[i]));
            end
            i1_reg <= s_axis_tdata[127:96];
            i2_reg <= i1_reg;
            i3_reg <= i2_reg;
            i4_reg <= i3_reg;
            out_reg <= {i4_reg, m4_reg[2], m4_reg[1], m4_reg[0]};
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid && !pose_busy && !cfg_wr_en) |-> s_axis_tready)
        else $error("not ready with empty output");
    a_nopose: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tready && !pose_valid) |=> !v_reg[0])
        else $error("item entered without a pose");

endmodule

// ===== tb/sv/point_transform_crop_filter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for point_transform_crop_filter_core: directed table, then random points
// under several pose settings, checked against a transform predictor. Depends on ptcf_pkg.
module point_transform_crop_filter_core_tb;
    import ptcf_pkg::*;

    typedef struct packed {
        q_t          x;
        q_t          y;
        q_t          z;
        logic [31:0] inten;
    } point_t;

    typedef enum logic {ROW_PREDICT, ROW_DROPPED} row_kind_t;

    typedef struct {
        point_t    pt;
        row_kind_t kind;
    } point_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // point_x, point_y, point_z, point_intensity
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // map_x, map_y, map_z, map_intensity
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    // Predictor state: registers and the composed body-to-world transform.
    longint pose_regs [7];
    bit     pose_ok;
    longint world_tf [12];

    point_t map_points_q [$];
    int     mismatches = 0;
    bit     sender_idles = 1'b1;
    bit     receiver_idles = 1'b1;
    int     quiet_cycles = 0;

    point_transform_crop_filter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Q1.30 product with round half up; the arithmetic shift floors.
    function automatic longint round_mul(longint a, longint b);
        longint s;
        s = a * b + (64'sd1 <<< 29);
        return s >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rotation from the raw quaternion composed with the fixed mount.
    function automatic void rebuild_world_tf();
        longint qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, wx, wy, wz, acc;
        longint rq [9];
        qx = pose_regs[REG_QUAT_X]; qy = pose_regs[REG_QUAT_Y];
        qz = pose_regs[REG_QUAT_Z]; qw = pose_regs[REG_QUAT_W];
        xx = round_mul(qx, qx); yy = round_mul(qy, qy); zz = round_mul(qz, qz);
        xy = round_mul(qx, qy); xz = round_mul(qx, qz); yz = round_mul(qy, qz);
        wx = round_mul(qw, qx); wy = round_mul(qw, qy); wz = round_mul(qw, qz);
        rq[0] = clamp32(64'sd1073741824 - 2 * (yy + zz));
        rq[1] = clamp32(2 * (xy - wz));
        rq[2] = clamp32(2 * (xz + wy));
        rq[3] = clamp32(2 * (xy + wz));
        rq[4] = clamp32(64'sd1073741824 - 2 * (xx + zz));
        rq[5] = clamp32(2 * (yz - wx));
        rq[6] = clamp32(2 * (xz - wy));
        rq[7] = clamp32(2 * (yz + wx));
        rq[8] = clamp32(64'sd1073741824 - 2 * (xx + yy));
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = round_mul(rq[i*3], MountRot[j]) + round_mul(rq[i*3+1], MountRot[3+j])
                    + round_mul(rq[i*3+2], MountRot[6+j]);
                world_tf[i*3+j] = clamp32(acc);
            end
            acc = round_mul(rq[i*3], MountOff[0]) + round_mul(rq[i*3+1], MountOff[1])
                + round_mul(rq[i*3+2], MountOff[2]) + pose_regs[i];
            world_tf[9+i] = clamp32(acc);
        end
    endfunction

    // Returns 1 and the world point when the point survives the crop.
    function automatic bit predict_map_point(point_t p, output point_t r);
        longint src [3];
        longint body [3];
        longint wp [3];
        bit in_box;
        r = p;
        if (!pose_ok) begin
            return 1'b0;
        end
        src[0] = p.x; src[1] = p.y; src[2] = p.z;
        for (int i = 0; i < 3; i++) begin
            body[i] = clamp32(round_mul(RadarRot[i*3], src[0]) + round_mul(RadarRot[i*3+1], src[1])
                    + round_mul(RadarRot[i*3+2], src[2]) + RadarOff[i]);
        end
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (!(body[i] > BoxMin[i] && body[i] < BoxMax[i])) begin
                in_box = 1'b0;
            end
        end
        if (in_box) begin
            return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            wp[i] = clamp32(round_mul(world_tf[i*3], body[0]) + round_mul(world_tf[i*3+1], body[1])
                  + round_mul(world_tf[i*3+2], body[2]) + world_tf[9+i]);
        end
        r.x = q_t'(wp[0]); r.y = q_t'(wp[1]); r.z = q_t'(wp[2]);
        return 1'b1;
    endfunction

    function automatic bit idle_roll(bit enabled);
        return enabled && ($urandom_range(99) < 29);
    endfunction

    // Waits for the pipeline to empty, including points that were dropped in flight.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (map_points_q.size() == 0);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_POSE_VALID) begin
            pose_ok = value[0];
        end else begin
            pose_regs[idx] = longint'(signed'(value));
        end
        rebuild_world_tf();
    endtask

    task automatic write_pose(q_t px, q_t py, q_t pz, q_t qx, q_t qy, q_t qz, q_t qw,
                              logic [31:0] valid_word);
        drain();
        write_reg(REG_POSE_X, px);
        write_reg(REG_POSE_Y, py);
        write_reg(REG_POSE_Z, pz);
        write_reg(REG_QUAT_X, qx);
        write_reg(REG_QUAT_Y, qy);
        write_reg(REG_QUAT_Z, qz);
        write_reg(REG_QUAT_W, qw);
        write_reg(REG_POSE_VALID, valid_word);
        repeat (10) @(negedge aclk);
    endtask

    // Offers one item, called and returning at a falling edge.
    task automatic send_point(point_t p, output bit produced);
        point_t r;
        while (idle_roll(sender_idles)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.inten, p.z, p.y, p.x};
        do @(posedge aclk); while (!s_axis_tready);
        produced = predict_map_point(p, r);
        if (produced) begin
            map_points_q = {map_points_q, r};
        end
        @(negedge aclk);
    endtask

    function automatic q_t random_coord();
        if ($urandom_range(1)) begin
            return q_t'($urandom_range(524288)) - 32'sd262144;
        end
        return q_t'($urandom);
    endfunction

    function automatic q_t random_quat();
        return q_t'($urandom_range(32'd2147483648)) - 32'sd1073741824;
    endfunction

    // Result side: random stalls and comparison with the oldest expected point.
    always @(negedge aclk) begin
        m_axis_tready <= !idle_roll(receiver_idles);
    end

    always @(posedge aclk) begin
        point_t got;
        point_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[31:0];
            got.y = m_axis_tdata[63:32];
            got.z = m_axis_tdata[95:64];
            got.inten = m_axis_tdata[127:96];
            if (map_points_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: %h", m_axis_tdata);
                end
            end else begin
                want = map_points_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected x=%h y=%h z=%h i=%h, got x=%h y=%h z=%h i=%h",
                                 want.x, want.y, want.z, want.inten,
                                 got.x, got.y, got.z, got.inten);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item and no register is written.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= 5000) begin
            $display("** point_transform_crop_filter_core: FAILED **");
            $finish;
        end
    end

    point_row_t dropped_rows [4] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'h0}, ROW_DROPPED},
        '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff}, ROW_DROPPED},
        '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h0}, ROW_DROPPED},
        '{'{32'sd65536, -32'sd65536, 32'sd65536, 32'h5a5a5a5a}, ROW_DROPPED}
    };

    point_row_t valid_rows [16] = '{
        '{'{32'sd0, 32'sd0, 32'sd0, 32'h12345678}, ROW_DROPPED},
        '{'{32'sd65536, 32'sd0, 32'sd0, 32'h0}, ROW_PREDICT},
        '{'{32'sd0, 32'sd65536, 32'sd0, 32'hffffffff}, ROW_PREDICT},
        '{'{32'sd0, 32'sd0, 32'sd65536, 32'h1}, ROW_PREDICT},
        '{'{32'sd327680, 32'sd131072, -32'sd65536, 32'h80000000}, ROW_PREDICT},
        '{'{32'sh7fffffff, 32'sd0, 32'sd0, 32'h0000ffff}, ROW_PREDICT},
        '{'{32'sh80000000, 32'sd0, 32'sd0, 32'hffff0000}, ROW_PREDICT},
        '{'{32'sd0, 32'sh7fffffff, 32'sd0, 32'haaaaaaaa}, ROW_PREDICT},
        '{'{32'sd0, 32'sh80000000, 32'sd0, 32'h55555555}, ROW_PREDICT},
        '{'{32'sd0, 32'sd0, 32'sh7fffffff, 32'h0}, ROW_PREDICT},
        '{'{32'sd0, 32'sd0, 32'sh80000000, 32'h0}, ROW_PREDICT},
        '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff}, ROW_PREDICT},
        '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h0}, ROW_PREDICT},
        '{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'h0f0f0f0f}, ROW_PREDICT},
        '{'{32'sd6554, -32'sd6554, 32'sd3277, 32'h3}, ROW_PREDICT},
        '{'{-32'sd13107, 32'sd13107, -32'sd6554, 32'h4}, ROW_PREDICT}
    };

    task automatic run_rows(point_row_t rows [], string tag);
        bit produced;
        foreach (rows[k]) begin
            send_point(rows[k].pt, produced);
            if (rows[k].kind == ROW_DROPPED && produced) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%s row %0d: point was expected to be dropped", tag, k);
                end
            end
        end
    endtask

    task automatic run_random(int count);
        point_t p;
        bit produced;
        for (int k = 0; k < count; k++) begin
            p.x = random_coord();
            p.y = random_coord();
            p.z = random_coord();
            p.inten = $urandom;
            send_point(p, produced);
            // Hold the sender once until everything in flight has come out.
            if (k == count / 2) begin
                s_axis_tvalid <= 1'b0;
                wait (map_points_q.size() == 0);
                @(negedge aclk);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 7; i++) begin
            pose_regs[i] = 0;
        end
        pose_regs[REG_QUAT_W] = 64'sd1073741824;
        pose_ok = 1'b0;
        rebuild_world_tf();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (10) @(negedge aclk);

        // No pose yet: every point is dropped.
        run_rows(dropped_rows, "no pose");

        // Reset pose made valid, upper bits of the valid word ignored.
        drain();
        write_reg(REG_POSE_VALID, 32'hfffffffe);
        run_rows(dropped_rows, "valid word bit zero");
        drain();
        write_reg(REG_POSE_VALID, 32'h1);
        repeat (10) @(negedge aclk);
        run_rows(valid_rows, "reset pose");

        // Unnormalized quaternions and extreme positions.
        write_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 32'h1);
        run_rows(valid_rows, "max pose");
        write_pose(32'sh80000000, 32'sh80000000, 32'sh80000000,
                   -32'sd1073741824, -32'sd1073741824, -32'sd1073741824, -32'sd1073741824,
                   32'h1);
        run_rows(valid_rows, "min pose");

        // Random poses; one phase runs without any idling.
        for (int ph = 0; ph < 9; ph++) begin
            sender_idles = (ph != 4);
            receiver_idles = (ph != 4);
            write_pose(q_t'($urandom), q_t'($urandom), q_t'($urandom),
                       random_quat(), random_quat(), random_quat(), random_quat(),
                       (ph == 6) ? 32'h0 : ($urandom | 32'h1));
            run_random(150);
        end

        s_axis_tvalid <= 1'b0;
        wait (map_points_q.size() == 0);
        repeat (30) @(negedge aclk);
        if (mismatches == 0 && map_points_q.size() == 0) begin
            $display("** point_transform_crop_filter_core: PASSED **");
        end else begin
            $display("** point_transform_crop_filter_core: FAILED **");
        end
        $finish;
    end

endmodule
